// ===== rtl/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg
// types and constants shared by the sorted sleep/wakeup queue and its cells
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int unsigned WAKE_W  = 32;
  localparam int unsigned PID_W   = 6;
  localparam int unsigned DELAY_W = 12;
  localparam int unsigned TPS_W   = 24;
  localparam int unsigned PROD_W  = DELAY_W - 1 + TPS_W;  // non-negative delay only
  localparam int unsigned SUM_W   = PROD_W + 1;

  localparam logic [TPS_W-1:0]  TICKS_RESET = 24'd1000000;
  localparam logic [WAKE_W-1:0] WAKE_MAX    = 32'hFFFF_FFFF;

  // request types
  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_WOKEN = 2'd1;
  localparam logic [1:0] KIND_IDLE  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NEG  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic                      req_type;
    logic [PID_W-1:0]          proc_id;
    logic signed [DELAY_W-1:0] delay_seconds;
    logic [WAKE_W-1:0]         now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [PID_W-1:0] woken_proc;
    logic             last;
  } out_item_t;

  // one queue entry held by a cell
  typedef struct packed {
    logic [WAKE_W-1:0] wake;
    logic [PID_W-1:0]  pid;
  } entry_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [WAKE_W-1:0] wake;
    logic [PID_W-1:0]  pid;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_SUM,
    S_INS,
    S_TICK
  } state_t;

endpackage

// ===== rtl/ssq_cell.sv =====
// ----------------------------------------------------------------------------
// ssq_cell
// one slot of the sorted chain: keeps, takes the new entry or shifts
// ----------------------------------------------------------------------------
module ssq_cell
  import ssq_pkg::*;
(
  input  logic       clk,
  input  logic       occ,        // slot holds a live entry
  input  cell_ctrl_t ctrl,
  input  entry_t     prev_entry,
  input  logic       prev_keep,  // left neighbour stays put on insert
  input  entry_t     next_entry,
  output entry_t     entry,
  output logic       keep
);

  entry_t entry_r;
  entry_t entry_nxt;

  // stays in place when its wake time is at or before the new one
  assign keep  = occ && (entry_r.wake <= ctrl.wake);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (prev_keep) begin
        entry_nxt.wake = ctrl.wake;
        entry_nxt.pid  = ctrl.pid;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/sorted_sleep_wakeup_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_sleep_wakeup_queue
// timer queue kept in wake-time order in a chain of cells
// ----------------------------------------------------------------------------
// sleep request: capture, multiply, add and saturate, then insert into the
//   chain before the ack; one item at a time
// tick: one head pop per cycle for each woken entry, or a single nothing-due
//   item when none is due; back-pressure on out_ready stretches either
// reset: synchronous active-low rst_n empties the queue (entry count to zero)
//   and loads ticks_per_second with 1000000; cell contents are not cleared
module sorted_sleep_wakeup_queue
  import ssq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [TPS_W-1:0] cfg_wr_data
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // sequencer and registers
  state_t            state_r, state_nxt;
  in_item_t          req_r;
  logic [TPS_W-1:0]  tps_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [WAKE_W-1:0] wake_r, wake_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  out_item_t         out_item_r;

  // emit path into the output register
  logic              out_free;
  logic              emit;
  out_item_t         emit_item;

  // chain wiring
  cell_ctrl_t          ctrl;
  entry_t              entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keeps;
  logic [QUEUE_DEPTH-1:0] occ;
  logic [SUM_W-1:0]    sum;
  logic                head_due;
  logic                second_due;
  logic                is_full;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign out_free  = !out_valid_r || out_ready;

  assign is_full   = (count_r == CNT_W'(QUEUE_DEPTH));

  // wake = now + delay * tps; only non-negative delays get here
  assign prod_nxt = PROD_W'(req_r.delay_seconds[DELAY_W-2:0]) * PROD_W'(tps_r);
  assign sum      = SUM_W'(req_r.now) + SUM_W'(prod_r);
  assign wake_nxt = (sum[SUM_W-1:WAKE_W] != '0) ? WAKE_MAX : sum[WAKE_W-1:0];

  // head and its neighbour, compared against the tick time
  assign head_due   = occ[0] && (entries[0].wake <= req_r.now);
  assign second_due = occ[1] && (entries[1].wake <= req_r.now);

  // occupancy from the fill count: live entries sit at the low end
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_occ
    assign occ[g] = (CNT_W'(g) < count_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    emit      = 1'b0;
    emit_item = '{kind: KIND_ACK, status: STAT_OK, woken_proc: '0, last: 1'b1};
    ctrl      = '{ins: 1'b0, pop: 1'b0, wake: wake_r, pid: req_r.proc_id};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.req_type == REQ_TICK) ? S_TICK : S_CALC;
        end
      end
      S_CALC: begin
        // negative delay is checked before a full queue
        if (req_r.delay_seconds[DELAY_W-1] || is_full) begin
          if (out_free) begin
            emit             = 1'b1;
            emit_item.status = req_r.delay_seconds[DELAY_W-1] ? STAT_NEG : STAT_FULL;
            state_nxt        = S_IDLE;
          end
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        state_nxt = S_INS;
      end
      S_INS: begin
        if (out_free) begin
          ctrl.ins  = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (out_free) begin
          emit = 1'b1;
          if (head_due) begin
            ctrl.pop             = 1'b1;
            count_nxt            = count_r - CNT_W'(1);
            emit_item.kind       = KIND_WOKEN;
            emit_item.woken_proc = entries[0].pid;
            emit_item.last       = !second_due;
            if (!second_due) begin
              state_nxt = S_IDLE;
            end
          end else begin
            // only reachable before the first pop of a tick
            emit_item.kind = KIND_IDLE;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tps_r       <= TICKS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        tps_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    prod_r <= prod_nxt;
    wake_r <= wake_nxt;
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  // the cell chain: entry i takes from i-1 on insert and from i+1 on pop
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_k;

    if (g == 0) begin : g_head
      assign prev_e = entries[g];
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_e = entries[g-1];
      assign prev_k = keeps[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_e = entries[g];
    end else begin : g_inner
      assign next_e = entries[g+1];
    end

    ssq_cell u_cell (
      .clk        (clk),
      .occ        (occ[g]),
      .ctrl       (ctrl),
      .prev_entry (prev_e),
      .prev_keep  (prev_k),
      .next_entry (next_e),
      .entry      (entries[g]),
      .keep       (keeps[g])
    );
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |-> (count_r < CNT_W'(QUEUE_DEPTH)))
    else $error("insert into a full chain");

  a_pop_live: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> (count_r != '0))
    else $error("pop from an empty chain");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the count");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_item.kind != KIND_WOKEN) |-> emit_item.last)
    else $error("ack or nothing-due item without last");

endmodule

// ===== bench/ssq_result_checker.sv =====
// ----------------------------------------------------------------------------
// ssq_result_checker
// watches both channels of the sleep/wakeup queue, keeps its own sorted copy
// of the sleepers and compares every result item against the oldest prediction
// ----------------------------------------------------------------------------
module ssq_result_checker
  import ssq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [TPS_W-1:0] cfg_wr_data,
  output int unsigned      fail_count,
  output int unsigned      pending,
  output int unsigned      result_count,
  output int unsigned      woken_count,
  output int unsigned      reject_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [TPS_W-1:0]  tick_rate;
  logic [WAKE_W-1:0] sleeper_wake[$];
  logic [PID_W-1:0]  sleeper_pid[$];
  out_item_t         due_results[$];
  int unsigned       n_fail, n_results, n_woken, n_reject;

  initial begin
    tick_rate = TICKS_RESET;
    n_fail    = 0;
    n_results = 0;
    n_woken   = 0;
    n_reject  = 0;
  end

  // sorted insert on sleep, pop of all due sleepers on tick
  task automatic predict_wakeups(input in_item_t req);
    logic [63:0]       wake_sum;
    logic [WAKE_W-1:0] wake;
    int unsigned       pos;
    int unsigned       n_due;
    out_item_t         res;
    res = '0;
    if (req.req_type == REQ_SLEEP) begin
      res.kind = KIND_ACK;
      res.last = 1'b1;
      if (req.delay_seconds[DELAY_W-1]) begin
        res.status = STAT_NEG;
      end else if (sleeper_wake.size() >= QUEUE_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        wake_sum = {32'd0, req.now} + {52'd0, req.delay_seconds} * {40'd0, tick_rate};
        wake     = (wake_sum > {32'd0, WAKE_MAX}) ? WAKE_MAX : wake_sum[WAKE_W-1:0];
        pos = 0;
        // equal wake times keep arrival order
        while (pos < sleeper_wake.size() && sleeper_wake[pos] <= wake) pos++;
        sleeper_wake.insert(pos, wake);
        sleeper_pid.insert(pos, req.proc_id);
        res.status = STAT_OK;
      end
      due_results.push_back(res);
    end else begin
      n_due = 0;
      while (n_due < sleeper_wake.size() && sleeper_wake[n_due] <= req.now) n_due++;
      if (n_due == 0) begin
        res.kind = KIND_IDLE;
        res.last = 1'b1;
        due_results.push_back(res);
      end else begin
        for (int unsigned i = 0; i < n_due; i++) begin
          res.kind       = KIND_WOKEN;
          res.woken_proc = sleeper_pid.pop_front();
          res.last       = (i + 1 == n_due);
          void'(sleeper_wake.pop_front());
          due_results.push_back(res);
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t exp_res;
    if (!rst_n) begin
      tick_rate = TICKS_RESET;
      sleeper_wake.delete();
      sleeper_pid.delete();
      due_results.delete();
    end else begin
      if (cfg_wr_en) tick_rate = cfg_wr_data;
      if (in_valid && in_ready) predict_wakeups(in_data);
      if (out_valid && out_ready) begin
        n_results++;
        if (out_data.kind == KIND_WOKEN) n_woken++;
        if (out_data.kind == KIND_ACK && out_data.status != STAT_OK) n_reject++;
        if (due_results.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: result item with nothing outstanding: kind %0d status %0d proc %0d last %0d",
                     $realtime, out_data.kind, out_data.status, out_data.woken_proc,
                     out_data.last);
        end else begin
          exp_res = due_results.pop_front();
          if (out_data.kind !== exp_res.kind || out_data.status !== exp_res.status ||
              out_data.woken_proc !== exp_res.woken_proc || out_data.last !== exp_res.last) begin
            n_fail++;
            if (n_fail <= 10)
              $display("%0t: mismatch kind/status/proc/last expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       $realtime, exp_res.kind, exp_res.status, exp_res.woken_proc,
                       exp_res.last, out_data.kind, out_data.status, out_data.woken_proc,
                       out_data.last);
          end
        end
      end
    end
    pending      <= due_results.size();
    fail_count   <= n_fail;
    result_count <= n_results;
    woken_count  <= n_woken;
    reject_count <= n_reject;
  end

endmodule

// ===== bench/tb_sorted_sleep_wakeup_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_sleep_wakeup_queue
// drives sleep requests and clock ticks into the timer queue, with a directed
// opening, a fill to capacity and random traffic under four flow-control
// phases and four tick rates; the checker beside the block does the scoring
// ----------------------------------------------------------------------------
module tb_sorted_sleep_wakeup_queue;
  import ssq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 64;
  // worst case is far below this: ~175 items, most giving one result, and one
  // flush of 64 wake-ups
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  in_item_t         in_data     = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  out_item_t        out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [TPS_W-1:0] cfg_wr_data = '0;

  int unsigned fail_count, pending, result_count, woken_count, reject_count;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned n_sleeps      = 0;
  int unsigned n_ticks       = 0;

  // running system time for well-formed traffic, and the tick rate in force
  logic [WAKE_W-1:0] sys_time  = '0;
  logic [TPS_W-1:0]  tick_rate = TICKS_RESET;

  always #5 clk = ~clk;

  sorted_sleep_wakeup_queue #(
    .QUEUE_DEPTH (DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ssq_result_checker #(
    .QUEUE_DEPTH (DEPTH)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .woken_count  (woken_count),
    .reject_count (reject_count)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic in_item_t request_item(input logic req, input logic [PID_W-1:0] pid,
                                            input logic [DELAY_W-1:0] delay,
                                            input logic [WAKE_W-1:0] t);
    in_item_t item;
    item.req_type      = req;
    item.proc_id       = pid;
    item.delay_seconds = delay;
    item.now           = t;
    return item;
  endfunction

  // mostly sleeps at the current time with short delays and ticks that move
  // time forward by a few seconds, so entries really do fall due; the rest is
  // negative or huge delays and ticks at arbitrary times
  function automatic in_item_t random_request();
    in_item_t item;
    int unsigned roll;
    item.proc_id       = PID_W'($urandom);
    item.delay_seconds = DELAY_W'($urandom);
    item.now           = sys_time;
    if ($urandom_range(0, 99) < 55) begin
      item.req_type = REQ_SLEEP;
      roll = $urandom_range(0, 99);
      if (roll < 10)
        item.delay_seconds[DELAY_W-1] = 1'b1;
      else if (roll < 20)
        item.delay_seconds[DELAY_W-1] = 1'b0;
      else
        item.delay_seconds = DELAY_W'($urandom_range(0, 4));
      if ($urandom_range(0, 19) == 0) item.now = $urandom;
    end else begin
      item.req_type = REQ_TICK;
      sys_time = sys_time + 32'($urandom_range(0, 2)) * 32'(tick_rate)
                 + 32'($urandom_range(0, tick_rate));
      item.now = sys_time;
      if ($urandom_range(0, 19) == 0) item.now = $urandom;
    end
    return item;
  endfunction

  // present one item, with an optional idle gap in front; valid is left high
  // after acceptance so that a back-to-back item needs no second assignment
  task automatic offer_request(input in_item_t req);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    if (req.req_type == REQ_SLEEP) n_sleeps++;
    else n_ticks++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender until every predicted result item has come back
  task automatic settle_queue();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // let the block return to idle after the final item
    repeat (8) @(posedge clk);
  endtask

  task automatic set_tick_rate(input logic [TPS_W-1:0] rate);
    settle_queue();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    tick_rate   = rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned n_items, input int unsigned idle,
                           input int unsigned stall);
    send_idle_pct = idle;
    stall_pct     <= stall;
    for (int unsigned k = 0; k < n_items; k++) begin
      // now and then let the queue run dry mid-phase
      if ($urandom_range(0, 14) == 0) settle_queue();
      offer_request(random_request());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening at the reset tick rate, no idling on either side
    offer_request(request_item(REQ_TICK,  6'd0,  12'd0,    32'd0));          // empty queue
    offer_request(request_item(REQ_SLEEP, 6'd0,  12'd0,    32'd0));
    offer_request(request_item(REQ_SLEEP, 6'd63, 12'd0,    32'd0));          // same wake time
    offer_request(request_item(REQ_SLEEP, 6'd5,  12'hFFF,  32'd0));          // delay -1
    offer_request(request_item(REQ_SLEEP, 6'd7,  12'h800,  32'hFFFF_FFFF));  // most negative
    offer_request(request_item(REQ_SLEEP, 6'd9,  12'd2047, 32'hFFFF_FFFF));  // saturates
    offer_request(request_item(REQ_SLEEP, 6'd10, 12'd2047, 32'd0));
    offer_request(request_item(REQ_SLEEP, 6'd11, 12'd1,    32'd100));
    offer_request(request_item(REQ_TICK,  6'd33, 12'd77,   32'd0));          // wakes 0 then 63
    offer_request(request_item(REQ_TICK,  6'd0,  12'd0,    32'd1000099));    // just too early
    offer_request(request_item(REQ_TICK,  6'd0,  12'd0,    32'd1000100));    // exactly due
    offer_request(request_item(REQ_SLEEP, 6'd20, 12'd3,    32'd5));          // same process twice
    offer_request(request_item(REQ_SLEEP, 6'd20, 12'd3,    32'd5));
    offer_request(request_item(REQ_SLEEP, 6'd42, 12'd0,    32'hFFFF_FFFF));  // ties the saturated one
    offer_request(request_item(REQ_TICK,  6'd0,  12'd0,    32'hFFFF_FFFE));
    offer_request(request_item(REQ_TICK,  6'd0,  12'd0,    32'hFFFF_FFFF));  // drains the rest
    offer_request(request_item(REQ_TICK,  6'd63, 12'hFFF,  32'hFFFF_FFFF));  // empty again

    // fill to capacity, then a negative delay (checked before fullness), two
    // refused sleeps and a flush that wakes all sixty-four in one go
    settle_queue();
    for (int unsigned k = 0; k < DEPTH; k++)
      offer_request(request_item(REQ_SLEEP, PID_W'($urandom), DELAY_W'($urandom_range(0, 3)),
                                 sys_time));
    offer_request(request_item(REQ_SLEEP, 6'd1, 12'hFFB, sys_time));
    offer_request(request_item(REQ_SLEEP, 6'd2, 12'd1,   sys_time));
    offer_request(request_item(REQ_SLEEP, 6'd3, 12'd0,   32'd0));
    offer_request(request_item(REQ_TICK,  6'd0, 12'd0,   32'hFFFF_FFFF));

    run_phase(15, 0, 0);

    // slowest rate with a mostly idle sender
    set_tick_rate(24'd1);
    run_phase(25, 85, 0);

    // fastest rate, where long delays saturate, with a stalling receiver
    set_tick_rate(24'hFF_FFFF);
    run_phase(25, 0, 85);

    // an arbitrary rate with moderate gaps on both sides
    set_tick_rate(TPS_W'($urandom_range(2, 999_999)));
    run_phase(25, 26, 26);

    settle_queue();
    repeat (20) @(posedge clk);

    $display("%0d requests sent (%0d sleeps, %0d ticks) at four tick rates and four flow patterns",
             n_sleeps + n_ticks, n_sleeps, n_ticks);
    $display("%0d result items checked: %0d wake-ups, %0d refused sleeps, %0d mismatches",
             result_count, woken_count, reject_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ssq_pkg.sv
rtl/ssq_cell.sv
rtl/sorted_sleep_wakeup_queue.sv
bench/ssq_result_checker.sv
bench/tb_sorted_sleep_wakeup_queue.sv
